// ----- design/business_day_adjust_top_defines.svh -----
// Assertion macros shared by the business-day adjustment RTL.
// Each macro expands to one concurrent assertion clocked by clk_i and gated by rst_ni.
`ifndef BUSINESS_DAY_ADJUST_TOP_DEFINES_SVH
`define BUSINESS_DAY_ADJUST_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bda_pkg.sv -----
// Shared types, constants and calendar helper functions for business-day adjustment.
// No dependencies; used by bda_calc and business_day_adjust_top.
package bda_pkg;

  localparam logic [11:0] YearMin = 12'd1900;
  localparam logic [11:0] YearMax = 12'd2200;

  localparam logic [2:0] WdSun = 3'd0;
  localparam logic [2:0] WdMon = 3'd1;
  localparam logic [2:0] WdFri = 3'd5;
  localparam logic [2:0] WdSat = 3'd6;

  localparam logic [3:0] MonJan = 4'd1;
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonMar = 4'd3;
  localparam logic [3:0] MonDec = 4'd12;

  typedef enum logic [1:0] {
    CONV_NONE       = 2'd0,
    CONV_FOLLOW     = 2'd1,
    CONV_PRECEDE    = 2'd2,
    CONV_MOD_FOLLOW = 2'd3
  } bda_conv_e;

  // One date request as it arrives on the input stream.
  typedef struct packed {
    bda_conv_e   convention;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
  } bda_req_t;

  // One adjusted result.
  typedef struct packed {
    logic        date_valid;
    logic        moved;
    logic [2:0]  weekday;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
  } bda_res_t;

  // Length of a month; an out-of-range month code reads as 31.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      MonFeb:                  n = leap ? 5'd29 : 5'd28;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  // floor(13 * (mm + 1) / 5) for the shifted month mm = 3..14.
  function automatic logic [5:0] month_offset(input logic [3:0] mm);
    logic [5:0] off;
    case (mm)
      4'd3:    off = 6'd10;
      4'd4:    off = 6'd13;
      4'd5:    off = 6'd15;
      4'd6:    off = 6'd18;
      4'd7:    off = 6'd20;
      4'd8:    off = 6'd23;
      4'd9:    off = 6'd26;
      4'd10:   off = 6'd28;
      4'd11:   off = 6'd31;
      4'd12:   off = 6'd33;
      4'd13:   off = 6'd36;
      4'd14:   off = 6'd39;
      default: off = 6'd0;
    endcase
    return off;
  endfunction

  // Modulo 7 by folding octal digits, since 8 is 1 modulo 7.
  function automatic logic [2:0] mod7(input logic [9:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    s3 = s2[2:0] + 3'(s2[3]);
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

// ----- design/bda_calc.sv -----
// Combinational date check, weekday and weekend roll for one registered request.
// Depends on bda_pkg for the request and result types and calendar functions.
module bda_calc (
  input  bda_pkg::bda_req_t req_i,
  output bda_pkg::bda_res_t res_o
);
  import bda_pkg::*;

  logic [4:0]  d;
  logic [3:0]  m;
  logic [11:0] y;
  logic        leap;
  logic [4:0]  dim;
  logic        valid;

  logic [3:0]  mm;
  logic [11:0] yy;
  logic [4:0]  cent;
  logic [11:0] cent_base;
  logic [6:0]  yr_in_cent;
  logic [9:0]  zsum;
  logic [2:0]  wd;
  logic        weekend;

  logic [5:0]  fwd_sum;
  logic [4:0]  fwd_day;
  logic [3:0]  fwd_month;
  logic [11:0] fwd_year;
  logic [1:0]  bwd_step;
  logic [3:0]  prev_month;
  logic [4:0]  bwd_day;
  logic [3:0]  bwd_month;
  logic [11:0] bwd_year;
  logic        use_fwd;
  logic        use_bwd;

  assign d = req_i.in_day;
  assign m = req_i.in_month;
  assign y = req_i.in_year;

  // Gregorian leap year; within 1900..2200 only 2000 is a leap century.
  assign leap = (y[1:0] == 2'b00) && (y != 12'd1900) && (y != 12'd2100) && (y != 12'd2200);
  assign dim  = month_days(m, leap);

  // Range and month-length checks.
  assign valid = (y >= YearMin) && (y <= YearMax) && (m >= MonJan) && (m <= MonDec) &&
                 (d != 5'd0) && (d <= dim);

  // Zeller's congruence: January and February count as months 13 and 14.
  assign mm = (m < MonMar) ? m + 4'd12 : m;
  assign yy = (m < MonMar) ? y - 12'd1 : y;

  // Century split by comparison, the year range covers five centuries.
  always_comb begin
    if (yy < 12'd1900) begin
      cent = 5'd18;
      cent_base = 12'd1800;
    end else if (yy < 12'd2000) begin
      cent = 5'd19;
      cent_base = 12'd1900;
    end else if (yy < 12'd2100) begin
      cent = 5'd20;
      cent_base = 12'd2000;
    end else if (yy < 12'd2200) begin
      cent = 5'd21;
      cent_base = 12'd2100;
    end else begin
      cent = 5'd22;
      cent_base = 12'd2200;
    end
  end

  assign yr_in_cent = 7'(yy - cent_base);

  // The extra 6 maps Zeller's Saturday-based count to a Sunday-based one.
  assign zsum = 10'(d) + 10'(month_offset(mm)) + 10'(yr_in_cent) + 10'(yr_in_cent[6:2]) +
                10'(cent[4:2]) + 10'(cent) * 10'd5 + 10'd6;
  assign wd = mod7(zsum);
  assign weekend = (wd == WdSun) || (wd == WdSat);

  // Forward roll: Saturday moves two days, Sunday one, to reach Monday.
  assign fwd_sum = 6'(d) + ((wd == WdSat) ? 6'd2 : 6'd1);
  always_comb begin
    if (fwd_sum <= 6'(dim)) begin
      fwd_day   = fwd_sum[4:0];
      fwd_month = m;
      fwd_year  = y;
    end else begin
      fwd_day   = 5'(fwd_sum - 6'(dim));
      fwd_month = (m == MonDec) ? MonJan : m + 4'd1;
      fwd_year  = (m == MonDec) ? y + 12'd1 : y;
    end
  end

  // Backward roll: Saturday moves one day, Sunday two, to reach Friday.
  assign bwd_step   = (wd == WdSun) ? 2'd2 : 2'd1;
  assign prev_month = (m == MonJan) ? MonDec : m - 4'd1;
  always_comb begin
    if (d > 5'(bwd_step)) begin
      bwd_day   = d - 5'(bwd_step);
      bwd_month = m;
      bwd_year  = y;
    end else begin
      bwd_day   = month_days(prev_month, leap) + d - 5'(bwd_step);
      bwd_month = prev_month;
      bwd_year  = (m == MonJan) ? y - 12'd1 : y;
    end
  end

  // Pick the roll direction from the convention.
  always_comb begin
    use_fwd = 1'b0;
    use_bwd = 1'b0;
    case (req_i.convention)
      CONV_NONE: begin
      end
      CONV_FOLLOW: begin
        use_fwd = weekend;
      end
      CONV_PRECEDE: begin
        use_bwd = weekend;
      end
      CONV_MOD_FOLLOW: begin
        use_fwd = weekend && (fwd_month == m);
        use_bwd = weekend && (fwd_month != m);
      end
      default: begin
      end
    endcase
  end

  // Assemble the result; an invalid date passes through unchanged with date_valid low.
  always_comb begin
    res_o.date_valid = valid;
    res_o.out_day    = d;
    res_o.out_month  = m;
    res_o.out_year   = y;
    res_o.weekday    = WdSun;
    res_o.moved      = 1'b0;
    if (valid) begin
      res_o.weekday = wd;
      if (use_fwd) begin
        res_o.out_day   = fwd_day;
        res_o.out_month = fwd_month;
        res_o.out_year  = fwd_year;
        res_o.weekday   = WdMon;
        res_o.moved     = 1'b1;
      end else if (use_bwd) begin
        res_o.out_day   = bwd_day;
        res_o.out_month = bwd_month;
        res_o.out_year  = bwd_year;
        res_o.weekday   = WdFri;
        res_o.moved     = 1'b1;
      end
    end
  end

endmodule

// ----- design/business_day_adjust_top.sv -----
// Top level of the business-day adjustment block: input register, calc logic, result register.
// Depends on bda_pkg, bda_calc and business_day_adjust_top_defines.svh.
//
//   Channel   Direction  Contents
//   s_axis    in         date request: day, month, year, convention
//   m_axis    out        adjusted date, weekday, moved flag; tuser carries date_valid
//
// Each request is held first in the input register and then in the result register,
// with the calc logic between the two.
// Throughput is one request per cycle while m_axis is ready; the calc logic is stateless.
// Reset clears only the two stage valid bits; payload registers are not reset.
// A stalled result holds its register, and the input register still takes a request
// while it is empty or draining into the result register.
`include "business_day_adjust_top_defines.svh"

module business_day_adjust_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [4:0] in_day, [8:5] in_month, [20:9] in_year, [22:21] convention, [23] zero
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [4:0] out_day, [8:5] out_month, [20:9] out_year, [23:21] weekday, [24] moved,
  // [31:25] zero
  output logic [31:0] m_axis_tdata_o,
  // [0] date_valid
  output logic        m_axis_tuser_o
);
  import bda_pkg::*;

  logic     s1_valid_q, s1_valid_d;
  bda_req_t s1_req_q;
  logic     s2_valid_q, s2_valid_d;
  bda_res_t s2_res_q;
  bda_res_t calc_res;
  logic     s1_ready;
  logic     s2_ready;

  // Stage readiness: a stage can load when empty or when it drains this cycle.
  assign s2_ready = !s2_valid_q || m_axis_tready_i;
  assign s1_ready = !s1_valid_q || s2_ready;

  assign s1_valid_d = s1_ready ? s_axis_tvalid_i : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s1_ready) begin
      s1_req_q.in_day     <= s_axis_tdata_i[4:0];
      s1_req_q.in_month   <= s_axis_tdata_i[8:5];
      s1_req_q.in_year    <= s_axis_tdata_i[20:9];
      s1_req_q.convention <= bda_conv_e'(s_axis_tdata_i[22:21]);
    end
  end

  // Date check, weekday and roll.
  bda_calc u_calc (
    .req_i (s1_req_q),
    .res_o (calc_res)
  );

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_res_q <= calc_res;
    end
  end

  assign s_axis_tready_o = s1_ready;
  assign m_axis_tvalid_o = s2_valid_q;
  assign m_axis_tdata_o  = {7'd0, s2_res_q.moved, s2_res_q.weekday, s2_res_q.out_year,
                            s2_res_q.out_month, s2_res_q.out_day};
  assign m_axis_tuser_o  = s2_res_q.date_valid;

  // A blocked input register keeps its request.
  `BDA_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s2_ready, s1_valid_q && $stable(s1_req_q), "input register lost a stalled request")

  // Back-pressure reaches the input only when both stages are full and stalled.
  `BDA_ASSERT_NOW(a_ready_low, !s_axis_tready_o, s1_valid_q && s2_valid_q && !m_axis_tready_i, "input stalled with room in the pipeline")

  // A request in the input register moves on when the result register has room.
  `BDA_ASSERT_NEXT(a_s1_advance, s1_valid_q && s2_ready, s2_valid_q, "request dropped between stages")

  // A moved date is valid and lands on Monday or Friday.
  `BDA_ASSERT_NOW(a_moved_day, m_axis_tvalid_o && s2_res_q.moved, s2_res_q.date_valid && (s2_res_q.weekday == WdMon || s2_res_q.weekday == WdFri), "moved date not on Monday or Friday")

  // An invalid date reports weekday zero and is never moved.
  `BDA_ASSERT_NOW(a_invalid_pass, m_axis_tvalid_o && !s2_res_q.date_valid, s2_res_q.weekday == WdSun && !s2_res_q.moved, "invalid date was adjusted")

endmodule
